/* rtl/core/aar8_pkg.sv */
// Package: command codes, register codes and flag record for the 8-bit ALU core.
package aar8_pkg;

  typedef enum logic [4:0] {
    CMD_MOV  = 5'd0,  CMD_MVI  = 5'd1,  CMD_LXI  = 5'd2,  CMD_XCHG = 5'd3,
    CMD_ADD  = 5'd4,  CMD_ADC  = 5'd5,  CMD_SUB  = 5'd6,  CMD_SBB  = 5'd7,
    CMD_ANA  = 5'd8,  CMD_XRA  = 5'd9,  CMD_ORA  = 5'd10, CMD_CMP  = 5'd11,
    CMD_INR  = 5'd12, CMD_DCR  = 5'd13, CMD_INX  = 5'd14, CMD_DCX  = 5'd15,
    CMD_DAD  = 5'd16, CMD_DAA  = 5'd17, CMD_RLC  = 5'd18, CMD_RRC  = 5'd19,
    CMD_RAL  = 5'd20, CMD_RAR  = 5'd21, CMD_CMA  = 5'd22, CMD_CMC  = 5'd23,
    CMD_STC  = 5'd24, CMD_COND = 5'd25
  } cmd_t;

  localparam logic [2:0] REG_NONE = 3'd6;
  localparam logic [2:0] REG_A    = 3'd7;
  localparam logic [1:0] PAIR_DE  = 2'd1;
  localparam logic [1:0] PAIR_HL  = 2'd2;
  localparam logic [1:0] PAIR_SP  = 2'd3;

  localparam logic [7:0] DAA_LO = 8'h06;
  localparam logic [7:0] DAA_HI = 8'h60;

  typedef struct packed {
    logic z;
    logic s;
    logic p;
    logic c;
    logic a;
  } flags_t;

  // Request as captured at the input register.
  typedef struct packed {
    logic [4:0]  cmd;
    logic [2:0]  dest_reg;
    logic [2:0]  src_reg;
    logic        use_immediate;
    logic [1:0]  pair_sel;
    logic [15:0] immediate;
    logic [2:0]  cond_code;
  } req_t;

  // Architectural state write-back from the execute logic.
  typedef struct packed {
    logic [7:0]  b, c, d, e, h, l, a;
    logic [15:0] sp;
    flags_t      f;
  } arch_t;

endpackage

/* rtl/core/accumulator_alu_regfile_8bit_core.sv */
// Top level: 8080-style register file, ALU and flags, one instruction per request.
//
// Input channel (in_valid/in_stall) carries one instruction request; output
// channel (out_valid/out_stall) carries one result per request.
// Accepted requests go into an input register; from there the execute
// logic reads the register file and flags, writes them back and loads the
// result register once that register is free to take a new result.
// Throughput is one request per cycle while out_stall is low: the input
// register refills while the result register is being taken, so the only
// limit is the single read-modify-write of the architectural state per cycle.
// When the receiver stalls, the result register holds; the input register
// holds its request and in_stall rises once both are full.
// Reset (rst, synchronous) clears B,C,D,E,H,L,A, SP and all flags, and
// empties both pipeline registers.
module accumulator_alu_regfile_8bit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  cmd,
  input  logic [2:0]  dest_reg,
  input  logic [2:0]  src_reg,
  input  logic        use_immediate,
  input  logic [1:0]  pair_sel,
  input  logic [15:0] immediate,
  input  logic [2:0]  cond_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  acc_value,
  output logic [15:0] written_value,
  output logic        zero_flag,
  output logic        sign_flag,
  output logic        parity_flag,
  output logic        carry_flag,
  output logic        aux_carry_flag,
  output logic        cond_met
);
  import aar8_pkg::*;

  req_t        req;
  logic        req_valid;
  arch_t       arch, arch_next;
  logic [15:0] wv;
  logic        cm;
  logic        exec_go;

  assign exec_go  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !exec_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      req <= '{cmd, dest_reg, src_reg, use_immediate, pair_sel, immediate, cond_code};
    end
  end

  aar8_exec u_exec (
    .req      (req),
    .cur      (arch),
    .nxt      (arch_next),
    .wv       (wv),
    .cond_met (cm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      arch      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (exec_go) begin
        arch <= arch_next;
      end
      if (exec_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (exec_go) begin
      acc_value      <= arch_next.a;
      written_value  <= wv;
      zero_flag      <= arch_next.f.z;
      sign_flag      <= arch_next.f.s;
      parity_flag    <= arch_next.f.p;
      carry_flag     <= arch_next.f.c;
      aux_carry_flag <= arch_next.f.a;
      cond_met       <= cm;
    end
  end

endmodule

/* rtl/core/aar8_exec.sv */
// Execute logic: one instruction on the current architectural state.
module aar8_exec (
  input  aar8_pkg::req_t  req,
  input  aar8_pkg::arch_t cur,
  output aar8_pkg::arch_t nxt,
  output logic [15:0]     wv,
  output logic            cond_met
);
  import aar8_pkg::*;

  logic [7:0]  regs [8];
  logic [7:0]  opnd, a, srcv, dstv, addb, res8, corr;
  logic        cin, sub, cy;
  logic [8:0]  sum;
  logic [4:0]  hsum;
  logic [15:0] pair_v, hl, de;
  logic [16:0] dsum;
  logic        cv;

  function automatic logic [15:0] pair_of(input arch_t s, input logic [1:0] p);
    logic [15:0] v;
    case (p)
      2'd0:    v = {s.b, s.c};
      PAIR_DE: v = {s.d, s.e};
      PAIR_HL: v = {s.h, s.l};
      default: v = s.sp;
    endcase
    return v;
  endfunction

  function automatic arch_t put_pair(input arch_t s, input logic [1:0] p,
                                     input logic [15:0] v);
    arch_t o;
    o = s;
    case (p)
      2'd0:    {o.b, o.c} = v;
      PAIR_DE: {o.d, o.e} = v;
      PAIR_HL: {o.h, o.l} = v;
      default: o.sp = v;
    endcase
    return o;
  endfunction

  function automatic arch_t put_reg(input arch_t s, input logic [2:0] r,
                                    input logic [7:0] v);
    arch_t o;
    o = s;
    case (r)
      3'd0:    o.b = v;
      3'd1:    o.c = v;
      3'd2:    o.d = v;
      3'd3:    o.e = v;
      3'd4:    o.h = v;
      3'd5:    o.l = v;
      REG_A:   o.a = v;
      default: o = s;
    endcase
    return o;
  endfunction

  function automatic flags_t zsp(input flags_t f, input logic [7:0] x);
    flags_t o;
    o = f;
    o.z = (x == 8'd0);
    o.s = x[7];
    o.p = ~^x;
    return o;
  endfunction

  always_comb begin
    regs[0] = cur.b; regs[1] = cur.c; regs[2] = cur.d; regs[3] = cur.e;
    regs[4] = cur.h; regs[5] = cur.l; regs[6] = 8'd0; regs[7] = cur.a;
  end

  assign a      = cur.a;
  assign srcv   = regs[req.src_reg];
  assign dstv   = regs[req.dest_reg];
  assign opnd   = req.use_immediate ? req.immediate[7:0] : srcv;
  assign pair_v = pair_of(cur, req.pair_sel);
  assign hl     = {cur.h, cur.l};
  assign de     = {cur.d, cur.e};
  assign dsum   = {1'b0, hl} + {1'b0, pair_v};

  // Decimal adjust correction.
  always_comb begin
    corr = 8'd0;
    cy   = cur.f.c;
    if (a[3:0] > 4'd9 || cur.f.a) corr = corr | DAA_LO;
    if (a[7:4] > 4'd9 || (a[7:4] == 4'd9 && a[3:0] > 4'd9) || cur.f.c) begin
      corr = corr | DAA_HI;
      cy   = 1'b1;
    end
  end

  // Shared 8-bit adder for add, subtract, compare and decimal adjust.
  always_comb begin
    sub  = 1'b0;
    addb = opnd;
    cin  = 1'b0;
    case (cmd_t'(req.cmd))
      CMD_ADC: cin = cur.f.c;
      CMD_SUB, CMD_CMP: begin sub = 1'b1; addb = ~opnd; cin = 1'b1; end
      CMD_SBB: begin sub = 1'b1; addb = ~opnd; cin = ~cur.f.c; end
      CMD_DAA: addb = corr;
      default: ;
    endcase
  end
  assign sum  = {1'b0, a} + {1'b0, addb} + {8'd0, cin};
  assign hsum = {1'b0, a[3:0]} + {1'b0, addb[3:0]} + {4'd0, cin};
  assign cv   = sub ? ~sum[8] : sum[8];

  always_comb begin
    nxt  = cur;
    wv   = 16'd0;
    res8 = 8'd0;
    case (cmd_t'(req.cmd))
      CMD_MOV: begin wv = {8'd0, srcv}; nxt = put_reg(cur, req.dest_reg, srcv); end
      CMD_MVI: begin
        wv  = {8'd0, req.immediate[7:0]};
        nxt = put_reg(cur, req.dest_reg, req.immediate[7:0]);
      end
      CMD_LXI: begin wv = req.immediate; nxt = put_pair(cur, req.pair_sel, req.immediate); end
      CMD_XCHG: begin
        wv = de;
        nxt = put_pair(put_pair(cur, PAIR_DE, hl), PAIR_HL, de);
      end
      CMD_ADD, CMD_ADC, CMD_SUB, CMD_SBB: begin
        wv = {8'd0, sum[7:0]};
        nxt.a = sum[7:0];
        nxt.f = zsp(cur.f, sum[7:0]);
        nxt.f.a = hsum[4];
        nxt.f.c = cv;
      end
      CMD_CMP: begin
        nxt.f = zsp(cur.f, sum[7:0]);
        nxt.f.a = hsum[4];
        nxt.f.c = cv;
      end
      CMD_ANA, CMD_XRA, CMD_ORA: begin
        res8 = (req.cmd == CMD_ANA) ? (a & opnd) :
               (req.cmd == CMD_XRA) ? (a ^ opnd) : (a | opnd);
        wv = {8'd0, res8};
        nxt.a = res8;
        nxt.f = zsp(cur.f, res8);
        nxt.f.c = 1'b0;
        nxt.f.a = 1'b0;
      end
      CMD_INR, CMD_DCR: begin
        res8 = (req.cmd == CMD_INR) ? dstv + 8'd1 : dstv - 8'd1;
        wv = {8'd0, res8};
        nxt = put_reg(cur, req.dest_reg, res8);
        nxt.f = zsp(cur.f, res8);
        nxt.f.a = (req.cmd == CMD_INR) ? (res8[3:0] == 4'h0) : (res8[3:0] != 4'hF);
      end
      CMD_INX: begin wv = pair_v + 16'd1; nxt = put_pair(cur, req.pair_sel, pair_v + 16'd1); end
      CMD_DCX: begin wv = pair_v - 16'd1; nxt = put_pair(cur, req.pair_sel, pair_v - 16'd1); end
      CMD_DAD: begin
        wv = dsum[15:0];
        nxt = put_pair(cur, PAIR_HL, dsum[15:0]);
        nxt.f.c = dsum[16];
      end
      CMD_DAA: begin
        wv = {8'd0, sum[7:0]};
        nxt.a = sum[7:0];
        nxt.f = zsp(cur.f, sum[7:0]);
        nxt.f.a = hsum[4];
        nxt.f.c = cy;
      end
      CMD_RLC: begin res8 = {a[6:0], a[7]}; wv = {8'd0, res8}; nxt.a = res8; nxt.f.c = a[7]; end
      CMD_RRC: begin res8 = {a[0], a[7:1]}; wv = {8'd0, res8}; nxt.a = res8; nxt.f.c = a[0]; end
      CMD_RAL: begin
        res8 = {a[6:0], cur.f.c}; wv = {8'd0, res8}; nxt.a = res8; nxt.f.c = a[7];
      end
      CMD_RAR: begin
        res8 = {cur.f.c, a[7:1]}; wv = {8'd0, res8}; nxt.a = res8; nxt.f.c = a[0];
      end
      CMD_CMA: begin res8 = ~a; wv = {8'd0, res8}; nxt.a = res8; end
      CMD_CMC: nxt.f.c = ~cur.f.c;
      CMD_STC: nxt.f.c = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    case (req.cond_code[2:1])
      2'd0:    cond_met = nxt.f.z;
      2'd1:    cond_met = nxt.f.c;
      2'd2:    cond_met = nxt.f.p;
      default: cond_met = nxt.f.s;
    endcase
    if (!req.cond_code[0]) cond_met = ~cond_met;
  end

endmodule

/* rtl/core/aar8_checker.sv */
// Port checker for the 8-bit ALU core, bound to the top level.
module aar8_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  acc_value,
  input logic [15:0] written_value,
  input logic        carry_flag
);
  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(written_value) && $stable(acc_value)
      && $stable(carry_flag))
    else $error("stalled result changed");

  // Input never stalls while the output side is free.
  a_nostall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // A request accepted while out_stall is low reaches out_valid via both registers.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_stall |=> ##1 out_valid)
    else $error("result missing");

  // Nothing comes out of reset.
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");
endmodule

bind accumulator_alu_regfile_8bit_core aar8_checker u_aar8_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .acc_value     (acc_value),
  .written_value (written_value),
  .carry_flag    (carry_flag)
);
